FILE: design/ipv4_rx_header_checker_unit_defines.svh
// Assertion macros used by the port checker of the IPv4 receive header checker.
`ifndef IPV4_RX_HEADER_CHECKER_UNIT_DEFINES_SVH
`define IPV4_RX_HEADER_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ihc_pkg.sv
// Types and constants of the IPv4 receive header checker.
package ihc_pkg;

  // Verdict codes, in the order the checks are applied.
  typedef enum logic [2:0] {
    STATUS_ACCEPT    = 3'd0,
    STATUS_SHORT     = 3'd1,
    STATUS_VERSION   = 3'd2,
    STATUS_HDR_LEN   = 3'd3,
    STATUS_TOTAL_LEN = 3'd4,
    STATUS_CHECKSUM  = 3'd5,
    STATUS_NOT_LOCAL = 3'd6
  } status_t;

  // Byte offsets of the header fields within the packet.
  localparam logic [15:0] OFS_VER_IHL   = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI   = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO   = 16'd3;
  localparam logic [15:0] OFS_PROTOCOL  = 16'd9;
  localparam logic [15:0] OFS_CSUM_HI   = 16'd10;
  localparam logic [15:0] OFS_CSUM_LO   = 16'd11;
  localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
  localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
  localparam logic [15:0] OFS_DST_FIRST = 16'd16;
  localparam logic [15:0] OFS_DST_LAST  = 16'd19;

  localparam logic [15:0] MIN_PKT_BYTES = 16'd20;
  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
  localparam logic [3:0]  VERSION_IPV4  = 4'd4;
  localparam logic [15:0] BYTE_CNT_MAX  = 16'hFFFF;

  localparam int unsigned OUT_TDATA_W = 88;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]  fill;
    logic [15:0] padding_bytes;
    logic [15:0] payload_bytes;
    logic [5:0]  header_bytes;
    logic [31:0] source_address;
    logic [7:0]  protocol_number;
    status_t     status;
  } out_item_t;

endpackage

FILE: design/ipv4_rx_header_checker_unit.sv
// IPv4 receive header checker: byte-wise header capture, checksum and verdict.
// Takes a received IPv4 packet one byte per item (tlast on the final byte) and
// returns one verdict item per packet, issued after the final byte; other bytes
// give no result. Each byte passes an input register and is folded into the
// header state in the following cycle, a final byte only once the output is
// free, so one byte is taken every clock cycle while the input register is not
// stuck behind an untaken verdict; the verdict passes the input register and
// then the output register to out_tdata and is held until taken. The checks are
// applied in order: short packet, version, header length, total length, header
// checksum, destination against cfg_wr_data as last written (zero after reset).
// Payload and padding lengths are zero unless the packet is accepted, and the
// received length saturates at 65535.
module ipv4_rx_header_checker_unit
  import ihc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] status, [10:3] protocol_number, [42:11] source_address,
  // [48:43] header_bytes, [64:49] payload_bytes, [80:65] padding_bytes, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        out_free;
  logic        proc;

  logic [31:0] local_ip_r;

  logic [15:0] byte_count_r,  byte_count_nxt;
  logic [15:0] csum_r,        csum_nxt;
  logic [7:0]  pending_r,     pending_nxt;
  logic [3:0]  version_r,     version_nxt;
  logic [3:0]  hdr_words_r,   hdr_words_nxt;
  logic [15:0] total_len_r,   total_len_nxt;
  logic [15:0] stored_csum_r, stored_csum_nxt;
  logic [7:0]  protocol_r,    protocol_nxt;
  logic [31:0] source_r,      source_nxt;
  logic [31:0] dest_r,        dest_nxt;

  logic        out_vld_r,  out_vld_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [15:0] idx;
  logic [7:0]  csum_byte;
  logic [15:0] csum_word;
  logic [16:0] csum_sum17;
  logic [15:0] csum_fold;
  logic [15:0] hdr_limit;
  logic [5:0]  hdr_bytes;
  status_t     verdict;

  assign out_free  = !out_vld_r || out_tready;
  // A non-final byte never waits on the output side.
  assign proc      = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || proc;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_item_r;

  assign idx        = byte_count_r;
  assign csum_byte  = (idx == OFS_CSUM_HI || idx == OFS_CSUM_LO) ? 8'd0 : in_byte_r;
  assign csum_word  = {pending_r, csum_byte};
  assign csum_sum17 = {1'b0, csum_r} + {1'b0, csum_word};
  assign csum_fold  = csum_sum17[15:0] + {15'd0, csum_sum17[16]};

  // The header length may arrive with this very byte, so the limit uses the new value.
  assign hdr_limit = (idx == OFS_VER_IHL) ? {10'd0, in_byte_r[3:0], 2'b00} :
                                            {10'd0, hdr_words_r, 2'b00};

  // Header capture and checksum accumulation for the byte in the input register.
  always_comb begin
    version_nxt     = version_r;
    hdr_words_nxt   = hdr_words_r;
    total_len_nxt   = total_len_r;
    protocol_nxt    = protocol_r;
    stored_csum_nxt = stored_csum_r;
    source_nxt      = source_r;
    dest_nxt        = dest_r;
    pending_nxt     = pending_r;
    csum_nxt        = csum_r;
    byte_count_nxt  = byte_count_r;

    if (proc) begin
      if (idx == OFS_VER_IHL) begin
        version_nxt   = in_byte_r[7:4];
        hdr_words_nxt = in_byte_r[3:0];
      end else if (idx == OFS_TLEN_HI) begin
        total_len_nxt[15:8] = in_byte_r;
      end else if (idx == OFS_TLEN_LO) begin
        total_len_nxt[7:0] = in_byte_r;
      end else if (idx == OFS_PROTOCOL) begin
        protocol_nxt = in_byte_r;
      end else if (idx == OFS_CSUM_HI) begin
        stored_csum_nxt[15:8] = in_byte_r;
      end else if (idx == OFS_CSUM_LO) begin
        stored_csum_nxt[7:0] = in_byte_r;
      end else if (idx inside {[OFS_SRC_FIRST:OFS_SRC_LAST]}) begin
        // Offset 12 lands in the top byte, offset 15 in the bottom one.
        source_nxt[{~idx[1:0], 3'b000} +: 8] = source_r[{~idx[1:0], 3'b000} +: 8] | in_byte_r;
      end else if (idx inside {[OFS_DST_FIRST:OFS_DST_LAST]}) begin
        dest_nxt[{~idx[1:0], 3'b000} +: 8] = dest_r[{~idx[1:0], 3'b000} +: 8] | in_byte_r;
      end

      if (idx < hdr_limit) begin
        if (!idx[0]) begin
          pending_nxt = csum_byte;
        end else begin
          csum_nxt = csum_fold;
        end
      end

      if (byte_count_r != BYTE_CNT_MAX) begin
        byte_count_nxt = byte_count_r + 16'd1;
      end
    end
  end

  assign hdr_bytes = {hdr_words_nxt, 2'b00};

  always_comb begin
    if (byte_count_nxt < MIN_PKT_BYTES) begin
      verdict = STATUS_SHORT;
    end else if (version_nxt != VERSION_IPV4) begin
      verdict = STATUS_VERSION;
    end else if (hdr_bytes < MIN_HDR_BYTES) begin
      verdict = STATUS_HDR_LEN;
    end else if (total_len_nxt > byte_count_nxt || total_len_nxt < {10'd0, hdr_bytes}) begin
      verdict = STATUS_TOTAL_LEN;
    end else if (~csum_nxt != stored_csum_nxt) begin
      verdict = STATUS_CHECKSUM;
    end else if (dest_nxt != local_ip_r) begin
      verdict = STATUS_NOT_LOCAL;
    end else begin
      verdict = STATUS_ACCEPT;
    end
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    if (proc && in_last_r) begin
      out_vld_nxt                  = 1'b1;
      out_item_nxt.fill            = '0;
      out_item_nxt.status          = verdict;
      out_item_nxt.protocol_number = protocol_nxt;
      out_item_nxt.source_address  = source_nxt;
      out_item_nxt.header_bytes    = hdr_bytes;
      if (verdict == STATUS_ACCEPT) begin
        out_item_nxt.payload_bytes = total_len_nxt - {10'd0, hdr_bytes};
        out_item_nxt.padding_bytes = byte_count_nxt - total_len_nxt;
      end else begin
        out_item_nxt.payload_bytes = '0;
        out_item_nxt.padding_bytes = '0;
      end
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      local_ip_r <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        local_ip_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    out_item_r <= out_item_nxt;
  end

  // Per-packet state; everything clears once the final byte is folded in.
  always_ff @(posedge clk) begin
    if (!rst_n || (proc && in_last_r)) begin
      byte_count_r  <= '0;
      csum_r        <= '0;
      pending_r     <= '0;
      version_r     <= '0;
      hdr_words_r   <= '0;
      total_len_r   <= '0;
      stored_csum_r <= '0;
      protocol_r    <= '0;
      source_r      <= '0;
      dest_r        <= '0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      csum_r        <= csum_nxt;
      pending_r     <= pending_nxt;
      version_r     <= version_nxt;
      hdr_words_r   <= hdr_words_nxt;
      total_len_r   <= total_len_nxt;
      stored_csum_r <= stored_csum_nxt;
      protocol_r    <= protocol_nxt;
      source_r      <= source_nxt;
      dest_r        <= dest_nxt;
    end
  end

endmodule

FILE: design/ihc_port_checker.sv
// Port-level assertions for the IPv4 receive header checker, bound to the top level.
`include "ipv4_rx_header_checker_unit_defines.svh"

module ihc_port_checker
  import ihc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  out_item_t item;
  assign item = out_tdata;

  // A verdict that is not taken stays on the port unchanged.
  `IHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "verdict changed while stalled")

  // Only accepted packets report payload and padding lengths.
  `IHC_ASSERT_NOW(a_drop_zero_len, clk, rst_n, out_tvalid && item.status != STATUS_ACCEPT, item.payload_bytes == 16'd0 && item.padding_bytes == 16'd0, "dropped packet reports nonzero lengths")

  // An accepted packet has a full-size header and no unused tdata bits set.
  `IHC_ASSERT_NOW(a_accept_hdr, clk, rst_n, out_tvalid && item.status == STATUS_ACCEPT, item.header_bytes >= MIN_HDR_BYTES && item.fill == 7'd0, "accepted packet with short header")

  // With the output idle, a verdict appears only after a final byte was taken.
  `IHC_ASSERT_NEXT(a_no_spurious, clk, rst_n, !out_tvalid && !$past(in_tvalid && in_tready && in_tlast), !out_tvalid, "verdict without a final byte")

endmodule

bind ipv4_rx_header_checker_unit ihc_port_checker u_ihc_port_checker (.*);

FILE: test/ipv4_verdict_checker.sv
// Verdict predictor and checker for the IPv4 receive header checker testbench.
`timescale 1ns / 1ps
module ipv4_verdict_checker
  import ihc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [31:0]            cfg_wr_data,
  output int unsigned            fail_count,
  output int unsigned            verdicts_pending,
  output int unsigned            verdicts_seen
);

  logic [31:0] local_addr;
  logic [15:0] rx_count;
  logic [15:0] csum_acc;
  logic [7:0]  csum_hi;
  logic [3:0]  ver_seen;
  logic [3:0]  ihl_seen;
  logic [15:0] tlen_seen;
  logic [15:0] csum_seen;
  logic [7:0]  proto_seen;
  logic [31:0] src_seen;
  logic [31:0] dst_seen;

  out_item_t expected_verdicts[$];

  task automatic clear_header();
    rx_count   = '0;
    csum_acc   = '0;
    csum_hi    = '0;
    ver_seen   = '0;
    ihl_seen   = '0;
    tlen_seen  = '0;
    csum_seen  = '0;
    proto_seen = '0;
    src_seen   = '0;
    dst_seen   = '0;
  endtask

  // Folds one received byte into the header state and, on the final byte,
  // queues the verdict the block must return for the packet.
  task automatic fold_rx_byte(input logic [7:0] b, input logic last);
    logic [15:0] idx;
    logic [16:0] sum;
    logic [7:0]  word_lo;
    int unsigned rx_len;
    int unsigned hdr_len;
    out_item_t   v;
    idx = rx_count;
    if (idx == OFS_VER_IHL) begin
      ver_seen = b[7:4];
      ihl_seen = b[3:0];
    end else if (idx == OFS_TLEN_HI) begin
      tlen_seen[15:8] = b;
    end else if (idx == OFS_TLEN_LO) begin
      tlen_seen[7:0] = b;
    end else if (idx == OFS_PROTOCOL) begin
      proto_seen = b;
    end else if (idx == OFS_CSUM_HI) begin
      csum_seen[15:8] = b;
    end else if (idx == OFS_CSUM_LO) begin
      csum_seen[7:0] = b;
    end else if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) begin
      src_seen = src_seen | (32'(b) << (8 * (OFS_SRC_LAST - idx)));
    end else if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) begin
      dst_seen = dst_seen | (32'(b) << (8 * (OFS_DST_LAST - idx)));
    end

    // The stored checksum bytes enter the sum as zero.
    if (int'(idx) < int'(ihl_seen) * 4) begin
      word_lo = (idx == OFS_CSUM_HI || idx == OFS_CSUM_LO) ? 8'd0 : b;
      if (!idx[0]) begin
        csum_hi = word_lo;
      end else begin
        sum = {1'b0, csum_acc} + {1'b0, csum_hi, word_lo};
        csum_acc = sum[16] ? sum[15:0] + 16'd1 : sum[15:0];
      end
    end

    if (rx_count != BYTE_CNT_MAX) rx_count = rx_count + 16'd1;

    if (last) begin
      rx_len  = rx_count;
      hdr_len = int'(ihl_seen) * 4;
      v = '0;
      v.protocol_number = proto_seen;
      v.source_address  = src_seen;
      v.header_bytes    = hdr_len[5:0];
      if (rx_len < MIN_PKT_BYTES) begin
        v.status = STATUS_SHORT;
      end else if (ver_seen != VERSION_IPV4) begin
        v.status = STATUS_VERSION;
      end else if (hdr_len < MIN_HDR_BYTES) begin
        v.status = STATUS_HDR_LEN;
      end else if (tlen_seen > rx_len || tlen_seen < hdr_len) begin
        v.status = STATUS_TOTAL_LEN;
      end else if (~csum_acc != csum_seen) begin
        v.status = STATUS_CHECKSUM;
      end else if (dst_seen != local_addr) begin
        v.status = STATUS_NOT_LOCAL;
      end else begin
        v.status        = STATUS_ACCEPT;
        v.payload_bytes = 16'(int'(tlen_seen) - int'(hdr_len));
        v.padding_bytes = 16'(rx_len - tlen_seen);
      end
      expected_verdicts.push_back(v);
      clear_header();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      local_addr = '0;
      clear_header();
      expected_verdicts.delete();
      fail_count    = 0;
      verdicts_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("verdict item with no packet waiting for one (status %0d)", got.status);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("protocol_number", 32'(want.protocol_number),
                      32'(got.protocol_number));
          check_field("source_address", want.source_address, got.source_address);
          check_field("header_bytes", 32'(want.header_bytes), 32'(got.header_bytes));
          check_field("payload_bytes", 32'(want.payload_bytes), 32'(got.payload_bytes));
          check_field("padding_bytes", 32'(want.padding_bytes), 32'(got.padding_bytes));
        end
      end
      if (cfg_wr_en) local_addr = cfg_wr_data;
      if (in_tvalid && in_tready) fold_rx_byte(in_tdata, in_tlast);
    end
    verdicts_pending = expected_verdicts.size();
  end

endmodule

FILE: test/ipv4_rx_header_checker_unit_tb.sv
// Testbench top: drives IPv4 packets and local addresses, and reports the verdict.
`timescale 1ns / 1ps
module ipv4_rx_header_checker_unit_tb;
  import ihc_pkg::*;

  localparam int unsigned RAND_BYTES    = 360;
  localparam int unsigned RAND_PACKETS  = 12;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef enum int {
    FLAW_NONE,
    FLAW_SHORT,
    FLAW_VERSION,
    FLAW_HDR_LEN,
    FLAW_TLEN_HIGH,
    FLAW_TLEN_LOW,
    FLAW_CHECKSUM,
    FLAW_NOT_LOCAL,
    FLAW_NOISE
  } flaw_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [31:0]            cfg_wr_data;

  int unsigned fail_count;
  int unsigned verdicts_pending;
  int unsigned verdicts_seen;

  logic [31:0] local_addr = '0;
  bit          no_idle = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned addr_settings = 0;
  int unsigned stall_cycles = 0;

  ipv4_rx_header_checker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  ipv4_verdict_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .verdicts_pending(verdicts_pending),
    .verdicts_seen   (verdicts_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FLAW_NONE;
    if (r < 61) return FLAW_SHORT;
    if (r < 66) return FLAW_VERSION;
    if (r < 71) return FLAW_HDR_LEN;
    if (r < 77) return FLAW_TLEN_HIGH;
    if (r < 83) return FLAW_TLEN_LOW;
    if (r < 89) return FLAW_CHECKSUM;
    if (r < 95) return FLAW_NOT_LOCAL;
    return FLAW_NOISE;
  endfunction

  function automatic logic [15:0] header_checksum(input logic [7:0] pkt[$], input int n);
    logic [16:0] acc;
    acc = '0;
    for (int i = 0; i + 1 < n; i += 2) begin
      acc = acc[15:0] + {pkt[i], pkt[i + 1]};
      if (acc[16]) acc = acc[15:0] + 17'd1;
    end
    return ~acc[15:0];
  endfunction

  // Builds a packet addressed to the current local address, then spoils it as asked.
  task automatic make_packet(input flaw_t flaw, input int ihl, input int body, input int pad,
                             ref logic [7:0] pkt[$]);
    int          hdr;
    int          n;
    logic [15:0] tlen;
    logic [15:0] csum;
    logic [31:0] dst;
    logic [31:0] mask;
    logic [3:0]  ver;
    pkt.delete();
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom()));
    end else begin
      hdr = ihl * 4;
      repeat (hdr + body + pad) pkt.push_back(8'($urandom()));
      tlen = 16'(hdr + body);
      dst  = local_addr;
      ver  = VERSION_IPV4;
      if (flaw == FLAW_VERSION) begin
        ver = 4'($urandom_range(0, 14));
        if (ver >= VERSION_IPV4) ver = ver + 4'd1;
      end
      pkt[0] = {ver, 4'(ihl)};
      if (flaw == FLAW_HDR_LEN) pkt[0][3:0] = 4'($urandom_range(0, 4));
      if (flaw == FLAW_TLEN_HIGH) tlen = 16'(pkt.size() + $urandom_range(1, 40));
      if (flaw == FLAW_TLEN_LOW) tlen = 16'($urandom_range(0, hdr - 1));
      if (flaw == FLAW_NOT_LOCAL) begin
        mask = $urandom();
        if (mask == 0) mask = 32'd1;
        dst = dst ^ mask;
      end
      pkt[2]  = tlen[15:8];
      pkt[3]  = tlen[7:0];
      pkt[10] = 8'd0;
      pkt[11] = 8'd0;
      pkt[16] = dst[31:24];
      pkt[17] = dst[23:16];
      pkt[18] = dst[15:8];
      pkt[19] = dst[7:0];
      csum = header_checksum(pkt, int'(pkt[0][3:0]) * 4);
      if (flaw == FLAW_CHECKSUM) begin
        mask = $urandom_range(1, 16'hFFFF);
        csum = csum ^ mask[15:0];
      end
      pkt[10] = csum[15:8];
      pkt[11] = csum[7:0];
      if (flaw == FLAW_SHORT) begin
        n = $urandom_range(1, 19);
        while (pkt.size() > n) void'(pkt.pop_back());
      end
    end
  endtask

  task automatic make_random_packet(ref logic [7:0] pkt[$]);
    int r;
    int ihl;
    int pad;
    r   = $urandom_range(0, 99);
    ihl = (r < 75) ? 5 : (r < 95) ? $urandom_range(6, 8) : 15;
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    make_packet(pick_flaw(), ihl, $urandom_range(0, 12), pad, pkt);
  endtask

  // Offers one item at the falling edge and returns at the falling edge after it is taken.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    for (int i = 0; i < pkt.size(); i++) begin
      push_byte(pkt[i], i == pkt.size() - 1);
      bytes_sent++;
    end
    packets_sent++;
  endtask

  // The address register is only written once every verdict is out and the pipe is empty.
  task automatic set_local_addr(input logic [31:0] addr);
    in_tvalid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    local_addr = addr;
    addr_settings++;
  endtask

  initial begin : sink_pacing
    int n;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0]  pkt[$];
    int unsigned rand_bytes;
    int unsigned rand_packets;
    int unsigned phase;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed packets with an all-zero local address.
    set_local_addr(32'h0000_0000);
    pkt = '{8'h45};
    send_packet(pkt);
    make_packet(FLAW_NONE, 5, 0, 0, pkt);
    send_packet(pkt);
    make_packet(FLAW_NONE, 5, 4, 0, pkt);
    void'(pkt.pop_back());
    while (pkt.size() > 19) void'(pkt.pop_back());
    send_packet(pkt);
    pkt.delete();
    repeat (20) pkt.push_back(8'h00);
    send_packet(pkt);
    make_packet(FLAW_VERSION, 5, 3, 0, pkt);
    send_packet(pkt);
    make_packet(FLAW_HDR_LEN, 5, 3, 1, pkt);
    send_packet(pkt);

    // Directed packets with an all-ones local address.
    set_local_addr(32'hFFFF_FFFF);
    pkt.delete();
    repeat (20) pkt.push_back(8'hFF);
    send_packet(pkt);
    make_packet(FLAW_TLEN_HIGH, 5, 2, 0, pkt);
    send_packet(pkt);
    make_packet(FLAW_TLEN_LOW, 6, 2, 2, pkt);
    send_packet(pkt);
    make_packet(FLAW_CHECKSUM, 5, 1, 0, pkt);
    send_packet(pkt);
    make_packet(FLAW_NOT_LOCAL, 5, 1, 0, pkt);
    send_packet(pkt);
    make_packet(FLAW_NONE, 15, 7, 3, pkt);
    send_packet(pkt);

    rand_bytes   = 0;
    rand_packets = 0;
    phase        = 0;
    while (rand_bytes < RAND_BYTES || rand_packets < RAND_PACKETS) begin
      if (rand_packets % 5 == 0) begin
        set_local_addr(($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom());
        no_idle = (phase % 3 == 2);
        phase++;
      end
      make_random_packet(pkt);
      send_packet(pkt);
      rand_bytes += pkt.size();
      rand_packets++;
    end

    in_tvalid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (verdicts_pending != 0) $error("%0d verdicts never arrived", verdicts_pending);

    $display("Sent %0d packets (%0d bytes) over %0d local address settings,",
             packets_sent, bytes_sent, addr_settings);
    $display("with every kind of header fault and stalls on both sides; %0d verdicts checked.",
             verdicts_seen);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
